/* hdl/lcdseq_pkg.sv */
// Shared types and constants for the character LCD sequencer.
// Depends on nothing; the controller, the top level and the testbench import it.
`timescale 1ns / 1ps

package lcdseq_pkg;

  // HD44780 command bytes used by the power-up and display sequences.
  localparam logic [7:0] CMD_FUNC_SET   = 8'h38;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0F;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_DDRAM_ROW1 = 8'h80;
  localparam logic [7:0] CMD_DDRAM_ROW2 = 8'hC0;

  // Reset value of the power-up wait register.
  localparam logic [7:0] WAIT_TICKS_RST = 8'd10;

  // Item opcodes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef enum logic [11:0] {
    PH_START     = 12'b0000_0000_0001,
    PH_INIT1     = 12'b0000_0000_0010,
    PH_WAITUP    = 12'b0000_0000_0100,
    PH_CMD_FUNC  = 12'b0000_0000_1000,
    PH_CMD_ENTRY = 12'b0000_0001_0000,
    PH_CMD_DISP  = 12'b0000_0010_0000,
    PH_CMD_CLEAR = 12'b0000_0100_0000,
    PH_READY     = 12'b0000_1000_0000,
    PH_CLR       = 12'b0001_0000_0000,
    PH_CURSOR    = 12'b0010_0000_0000,
    PH_CHAR      = 12'b0100_0000_0000,
    PH_HOLD      = 12'b1000_0000_0000
  } phase_t;

  // Where the data bus value of a transaction comes from.
  typedef enum logic [1:0] {
    DSEL_HOLD  = 2'd0,
    DSEL_CONST = 2'd1,
    DSEL_BUF   = 2'd2
  } dsel_t;

  // Bus and status state left by the latest accepted transaction.
  typedef struct packed {
    logic       rs;
    logic       e;
    logic       ready;
    dsel_t      dsel;
    logic [7:0] dconst;
  } lcdseq_status_t;

endpackage

/* hdl/lcdseq_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; used for the character buffer.
`timescale 1ns / 1ps

module lcdseq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/lcdseq_ctrl.sv */
// Sequencer state machine: phase, step counter and the RS, E and ready latches.
// Depends on lcdseq_pkg.
`timescale 1ns / 1ps

module lcdseq_ctrl #(
  parameter int LINE_CHARS      = 16,
  parameter int FIRST_ROW_CHARS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    item_en,
  input  logic                    tick_en,
  input  logic                    go,
  input  logic [7:0]              wait_ticks,
  output logic                    rd_req,
  output logic [7:0]              rd_col,
  output lcdseq_pkg::lcdseq_status_t status
);
  import lcdseq_pkg::*;

  localparam logic [8:0] LINE_N  = 9'(LINE_CHARS);
  localparam logic [7:0] ROW1_N  = 8'(FIRST_ROW_CHARS);

  phase_t     phase_r, phase_nxt;
  logic [7:0] step_r, step_nxt;
  logic       rs_r, rs_nxt;
  logic       e_r, e_nxt;
  logic       rdy_r, rdy_nxt;
  dsel_t      dsel_r, dsel_nxt;
  logic [7:0] dconst_r, dconst_nxt;
  logic [8:0] step_inc;

  assign step_inc = {1'b0, step_r} + 9'd1;

  always_comb begin
    phase_nxt  = phase_r;
    step_nxt   = step_r;
    rs_nxt     = rs_r;
    e_nxt      = e_r;
    rdy_nxt    = rdy_r;
    dsel_nxt   = DSEL_HOLD;
    dconst_nxt = dconst_r;
    rd_req     = 1'b0;
    if (tick_en) begin
      // Leave the current phase.
      case (phase_r)
        PH_START: phase_nxt = PH_INIT1;
        PH_INIT1: begin
          phase_nxt = PH_WAITUP;
          step_nxt  = '0;
        end
        PH_WAITUP: phase_nxt = (step_r < wait_ticks) ? PH_WAITUP : PH_CMD_FUNC;
        PH_CMD_FUNC: begin
          phase_nxt = PH_CMD_ENTRY;
          e_nxt     = 1'b0;
        end
        PH_CMD_ENTRY: begin
          phase_nxt = PH_CMD_DISP;
          e_nxt     = 1'b0;
        end
        PH_CMD_DISP: begin
          phase_nxt = PH_CMD_CLEAR;
          e_nxt     = 1'b0;
        end
        PH_CMD_CLEAR: begin
          phase_nxt = PH_READY;
          e_nxt     = 1'b0;
        end
        PH_READY: begin
          if (go) begin
            rdy_nxt   = 1'b0;
            phase_nxt = PH_CLR;
          end
        end
        PH_CLR: begin
          phase_nxt = PH_CURSOR;
          e_nxt     = 1'b0;
          step_nxt  = '0;
        end
        PH_CURSOR: begin
          phase_nxt = PH_CHAR;
          e_nxt     = 1'b0;
        end
        PH_CHAR: begin
          e_nxt = 1'b0;
          if (step_inc < LINE_N) begin
            step_nxt  = step_inc[7:0];
            phase_nxt = PH_CURSOR;
          end else begin
            phase_nxt = PH_HOLD;
          end
        end
        PH_HOLD: phase_nxt = go ? PH_HOLD : PH_READY;
        default: phase_nxt = PH_INIT1;
      endcase

      // Act on entering the new phase.
      case (phase_nxt)
        PH_INIT1:  rdy_nxt = 1'b0;
        PH_WAITUP: step_nxt = step_nxt + 8'd1;
        PH_CMD_FUNC, PH_CMD_ENTRY, PH_CMD_DISP, PH_CMD_CLEAR, PH_CLR: begin
          rs_nxt   = 1'b0;
          e_nxt    = 1'b1;
          dsel_nxt = DSEL_CONST;
          case (phase_nxt)
            PH_CMD_FUNC:  dconst_nxt = CMD_FUNC_SET;
            PH_CMD_ENTRY: dconst_nxt = CMD_ENTRY_MODE;
            PH_CMD_DISP:  dconst_nxt = CMD_DISP_ON;
            default:      dconst_nxt = CMD_CLEAR;
          endcase
        end
        PH_READY: rdy_nxt = 1'b1;
        PH_CURSOR: begin
          rs_nxt   = 1'b0;
          e_nxt    = 1'b1;
          dsel_nxt = DSEL_CONST;
          if (step_nxt < ROW1_N) begin
            dconst_nxt = CMD_DDRAM_ROW1 + step_nxt;
          end else begin
            dconst_nxt = CMD_DDRAM_ROW2 + step_nxt - ROW1_N;
          end
        end
        PH_CHAR: begin
          rs_nxt   = 1'b1;
          e_nxt    = 1'b1;
          dsel_nxt = DSEL_BUF;
          rd_req   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign rd_col = step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      step_r   <= '0;
      rs_r     <= 1'b0;
      e_r      <= 1'b0;
      rdy_r    <= 1'b0;
      dsel_r   <= DSEL_HOLD;
      dconst_r <= '0;
    end else if (item_en) begin
      phase_r  <= phase_nxt;
      step_r   <= step_nxt;
      rs_r     <= rs_nxt;
      e_r      <= e_nxt;
      rdy_r    <= rdy_nxt;
      dsel_r   <= dsel_nxt;
      dconst_r <= dconst_nxt;
    end
  end

  assign status = '{rs: rs_r, e: e_r, ready: rdy_r, dsel: dsel_r, dconst: dconst_r};

  // While the display run is going, the step counter stays inside the buffer.
  a_step_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CURSOR || phase_r == PH_CHAR) |-> ({1'b0, step_r} < LINE_N))
    else $error("step counter left the character line");

  // Ready is only ever raised in the ready phase.
  a_ready_phase: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rdy_r) |-> (phase_r == PH_READY))
    else $error("ready raised outside the ready phase");

endmodule

/* hdl/char_lcd_init_and_write_sequencer.sv */
// Top level of the character LCD sequencer: handshakes, configuration register,
// character buffer memory and result register. Depends on lcdseq_pkg,
// lcdseq_ram and lcdseq_ctrl.
`timescale 1ns / 1ps

// Drives an HD44780-style character LCD over its 8-bit bus. Every transaction
// on the input channel is either a timer tick (opcode 0), which advances the
// sequencer by one step, or a character load (opcode 1), which writes one
// position of the character buffer. Each input transaction yields exactly one
// result transaction carrying the bus state after it: data byte, RS, E and a
// ready flag. After reset the block waits cfg-programmed power-up ticks (a value
// of zero behaves as one), sends function set, entry mode, display on and clear,
// and raises ready. A tick with go high while ready clears the display and then
// writes every buffer position as a cursor command followed by a data write,
// and waits for go to drop. Loads to positions beyond the line are ignored; the
// buffer reads as all zero after reset until written, with no clearing pass.
// One transaction is accepted per clock cycle while results are taken. An
// accepted transaction passes the read stage, where the buffer memory read
// completes, and then the result register. While a result waits for out_ready
// the read stage still takes one more transaction; after that in_ready stays
// low until the result is taken. The power-up wait register should be written
// only while the block is idle.
module char_lcd_init_and_write_sequencer #(
  parameter int LINE_CHARS      = 16,
  parameter int FIRST_ROW_CHARS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_opcode,
  input  logic       in_go,
  input  logic [3:0] in_char_index,
  input  logic [7:0] in_char_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_bus_data,
  output logic       out_lcd_rs,
  output logic       out_lcd_e,
  output logic       out_ready_res
);
  import lcdseq_pkg::*;

  localparam int AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
  localparam logic [6:0] LINE_N = 7'(LINE_CHARS);

  logic           [7:0] wait_ticks_r;
  logic                 in_acc;
  logic                 tick_en;
  logic                 load_en;
  logic           [6:0] idx_ext;
  logic        [AW-1:0] waddr;
  logic                 rd_req;
  logic           [7:0] rd_col;
  logic        [AW-1:0] raddr;
  logic           [7:0] rdata;
  lcdseq_status_t       status;
  logic [LINE_CHARS-1:0] vld_r;
  logic                 vld_rd_r;
  logic                 p_vld_r;
  logic                 advance;
  logic                 out_valid_r;
  logic           [7:0] out_bus_data_r, out_bus_data_nxt;
  logic                 out_lcd_rs_r;
  logic                 out_lcd_e_r;
  logic                 out_ready_res_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_ticks_r <= WAIT_TICKS_RST;
    end else if (cfg_wr_en) begin
      wait_ticks_r <= cfg_wr_data;
    end
  end

  // The result register moves when empty or taken; the read stage in front of
  // it moves whenever the result register does, so an item is taken every
  // cycle as long as results are taken.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !p_vld_r || advance;
  assign in_acc   = in_valid && in_ready;
  assign tick_en  = in_acc && (in_opcode == OP_TICK);

  // Loads outside the line are dropped.
  assign idx_ext = {3'b000, in_char_index};
  assign waddr   = idx_ext[AW-1:0];
  assign load_en = in_acc && (in_opcode == OP_LOAD) && (idx_ext < LINE_N);

  lcdseq_ctrl #(
    .LINE_CHARS      (LINE_CHARS),
    .FIRST_ROW_CHARS (FIRST_ROW_CHARS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_en    (in_acc),
    .tick_en    (tick_en),
    .go         (in_go),
    .wait_ticks (wait_ticks_r),
    .rd_req     (rd_req),
    .rd_col     (rd_col),
    .status     (status)
  );

  // Character buffer. The next step count is below the line length whenever a
  // character write is due, so its low bits address the memory directly.
  assign raddr = rd_col[AW-1:0];

  lcdseq_ram #(
    .WIDTH (8),
    .DEPTH (LINE_CHARS)
  ) u_buf (
    .clk   (clk),
    .we    (load_en),
    .waddr (waddr),
    .wdata (in_char_value),
    .re    (rd_req),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Per-entry written flags stand in for the reset clear of the buffer: an
  // entry never loaded since reset reads as zero. A read and a write never
  // share a cycle, since each comes from a different transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (load_en) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req) begin
      vld_rd_r <= vld_r[raddr];
    end
  end

  // Read stage: holds one accepted transaction while its buffer read completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (in_acc) begin
      p_vld_r <= 1'b1;
    end else if (advance) begin
      p_vld_r <= 1'b0;
    end
  end

  // The result data register is also the data bus latch: a transaction that
  // does not drive the bus shows the byte held from the one before.
  always_comb begin
    case (status.dsel)
      DSEL_CONST: out_bus_data_nxt = status.dconst;
      DSEL_BUF:   out_bus_data_nxt = vld_rd_r ? rdata : 8'h00;
      default:    out_bus_data_nxt = out_bus_data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      out_bus_data_r  <= '0;
      out_lcd_rs_r    <= 1'b0;
      out_lcd_e_r     <= 1'b0;
      out_ready_res_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= p_vld_r;
      if (p_vld_r) begin
        out_bus_data_r  <= out_bus_data_nxt;
        out_lcd_rs_r    <= status.rs;
        out_lcd_e_r     <= status.e;
        out_ready_res_r <= status.ready;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bus_data  = out_bus_data_r;
  assign out_lcd_rs    = out_lcd_rs_r;
  assign out_lcd_e     = out_lcd_e_r;
  assign out_ready_res = out_ready_res_r;

  // A buffer read always belongs to a character data write.
  a_read_is_char: assert property (@(posedge clk) disable iff (!rst_n)
    rd_req |=> (status.dsel == DSEL_BUF) && status.rs && status.e)
    else $error("buffer read issued for a transaction that is not a data write");

  // The read stage is never dropped while the result register is blocked.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (p_vld_r && !advance) |=> p_vld_r && $stable(status))
    else $error("read stage lost its transaction under back-pressure");

  // While ready is reported no enable pulse is on the bus.
  a_ready_no_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready_res_r) |-> !out_lcd_e_r)
    else $error("enable strobe high while reporting ready");

  // A blocked result keeps its data byte.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_bus_data_r))
    else $error("result data changed while stalled");

endmodule

/* tb/char_lcd_init_and_write_sequencer_tb.sv */
// Self-checking testbench for the character LCD sequencer: random and directed
// tick and load transactions, a bus-state scoreboard and a stalling receiver.
// Depends on lcdseq_pkg and the char_lcd_init_and_write_sequencer top level.
`timescale 1ns / 1ps

module char_lcd_init_and_write_sequencer_tb;
  import lcdseq_pkg::*;

  // Sizes of the line, matching the instance below.
  localparam int NUM_CHARS  = 16;
  localparam int ROW1_CHARS = 8;

  // Input transaction count, directed part included, after which no new session starts.
  localparam int unsigned RANDOM_ITEMS = 1650;

  // Length of the single long receiver hold-off, in clock cycles.
  localparam int LONG_HOLD_CYCLES = 300;

  // Generous overall limit; the slowest correct run needs well under a tenth.
  localparam int unsigned TIMEOUT_NS = 5_000_000;

  // Stall patterns of the result receiver.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  // Bus and status state carried by one result transaction.
  typedef struct packed {
    logic [7:0] data;
    logic       rs;
    logic       e;
    logic       rdy;
  } lcd_bus_t;

  logic       clk;
  logic       rst_n         = 1'b0;
  logic       cfg_wr_en     = 1'b0;
  logic [7:0] cfg_wr_data   = '0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic       in_opcode     = OP_TICK;
  logic       in_go         = 1'b0;
  logic [3:0] in_char_index = '0;
  logic [7:0] in_char_value = '0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic [7:0] out_bus_data;
  logic       out_lcd_rs;
  logic       out_lcd_e;
  logic       out_ready_res;

  // Raised by the stimulus to ask the receiver for its long hold-off.
  bit hold_request = 1'b0;

  // Sender bookkeeping: transactions accepted so far and the current burst.
  int unsigned items_sent = 0;
  int          burst_left = 0;

  // Predicts the bus state after every accepted input transaction and keeps
  // the predictions in order until the matching result transaction arrives.
  class lcd_bus_scoreboard;
    phase_t      phase;
    logic [7:0]  step_cnt;
    logic [7:0]  chars [NUM_CHARS];
    logic [7:0]  bus_data;
    logic        bus_rs;
    logic        bus_e;
    logic        ready_q;
    logic [7:0]  wait_ticks;
    lcd_bus_t    pending [$];
    int unsigned mismatches;

    function new();
      phase      = PH_START;
      step_cnt   = '0;
      foreach (chars[i]) chars[i] = '0;
      bus_data   = '0;
      bus_rs     = 1'b0;
      bus_e      = 1'b0;
      ready_q    = 1'b0;
      wait_ticks = WAIT_TICKS_RST;
      mismatches = 0;
    endfunction

    function void set_wait_ticks(logic [7:0] v);
      wait_ticks = v;
    endfunction

    function void put_bus(logic rs, logic [7:0] b);
      bus_rs   = rs;
      bus_data = b;
      bus_e    = 1'b1;
    endfunction

    function void note_item(logic op, logic go, logic [3:0] idx, logic [7:0] val);
      phase_t   nxt;
      lcd_bus_t snap;
      if (op == OP_LOAD) begin
        if (int'(idx) < NUM_CHARS) chars[idx] = val;
      end else begin
        // First the transition out of the current phase, then the action of
        // the phase that has just been entered.
        nxt = phase;
        case (phase)
          PH_START: nxt = PH_INIT1;
          PH_INIT1: begin
            nxt      = PH_WAITUP;
            step_cnt = '0;
          end
          PH_WAITUP: nxt = (step_cnt < wait_ticks) ? PH_WAITUP : PH_CMD_FUNC;
          PH_CMD_FUNC: begin
            nxt   = PH_CMD_ENTRY;
            bus_e = 1'b0;
          end
          PH_CMD_ENTRY: begin
            nxt   = PH_CMD_DISP;
            bus_e = 1'b0;
          end
          PH_CMD_DISP: begin
            nxt   = PH_CMD_CLEAR;
            bus_e = 1'b0;
          end
          PH_CMD_CLEAR: begin
            nxt   = PH_READY;
            bus_e = 1'b0;
          end
          PH_READY: begin
            if (go) begin
              ready_q = 1'b0;
              nxt     = PH_CLR;
            end
          end
          PH_CLR: begin
            nxt      = PH_CURSOR;
            bus_e    = 1'b0;
            step_cnt = '0;
          end
          PH_CURSOR: begin
            nxt   = PH_CHAR;
            bus_e = 1'b0;
          end
          PH_CHAR: begin
            bus_e = 1'b0;
            if (int'(step_cnt) + 1 < NUM_CHARS) begin
              step_cnt = step_cnt + 8'd1;
              nxt      = PH_CURSOR;
            end else begin
              nxt = PH_HOLD;
            end
          end
          PH_HOLD: nxt = go ? PH_HOLD : PH_READY;
          default: nxt = PH_INIT1;
        endcase
        phase = nxt;
        case (phase)
          PH_INIT1:     ready_q = 1'b0;
          PH_WAITUP:    step_cnt = step_cnt + 8'd1;
          PH_CMD_FUNC:  put_bus(1'b0, CMD_FUNC_SET);
          PH_CMD_ENTRY: put_bus(1'b0, CMD_ENTRY_MODE);
          PH_CMD_DISP:  put_bus(1'b0, CMD_DISP_ON);
          PH_CMD_CLEAR: put_bus(1'b0, CMD_CLEAR);
          PH_READY:     ready_q = 1'b1;
          PH_CLR:       put_bus(1'b0, CMD_CLEAR);
          PH_CURSOR: begin
            if (int'(step_cnt) < ROW1_CHARS) begin
              put_bus(1'b0, 8'(CMD_DDRAM_ROW1 + step_cnt));
            end else begin
              put_bus(1'b0, 8'(CMD_DDRAM_ROW2 + step_cnt - ROW1_CHARS));
            end
          end
          PH_CHAR: begin
            put_bus(1'b1, (int'(step_cnt) < NUM_CHARS) ? chars[step_cnt[3:0]] : 8'h00);
          end
          default: ;
        endcase
      end
      snap.data = bus_data;
      snap.rs   = bus_rs;
      snap.e    = bus_e;
      snap.rdy  = ready_q;
      pending.push_back(snap);
    endfunction

    function void check_bus(logic [7:0] data, logic rs, logic e, logic rdy);
      lcd_bus_t want;
      if (pending.size() == 0) begin
        $error("result transaction with no expected transaction waiting");
        mismatches++;
      end else begin
        want = pending.pop_front();
        if (data !== want.data) begin
          $error("bus_data mismatch: expected %h, actual %h", want.data, data);
          mismatches++;
        end
        if (rs !== want.rs) begin
          $error("lcd_rs mismatch: expected %b, actual %b", want.rs, rs);
          mismatches++;
        end
        if (e !== want.e) begin
          $error("lcd_e mismatch: expected %b, actual %b", want.e, e);
          mismatches++;
        end
        if (rdy !== want.rdy) begin
          $error("ready_res mismatch: expected %b, actual %b", want.rdy, rdy);
          mismatches++;
        end
      end
    endfunction
  endclass

  lcd_bus_scoreboard sb;

  char_lcd_init_and_write_sequencer #(
    .LINE_CHARS     (NUM_CHARS),
    .FIRST_ROW_CHARS(ROW1_CHARS)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_go        (in_go),
    .in_char_index(in_char_index),
    .in_char_value(in_char_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_bus_data (out_bus_data),
    .out_lcd_rs   (out_lcd_rs),
    .out_lcd_e    (out_lcd_e),
    .out_ready_res(out_ready_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one input transaction and returns at the edge where it is taken.
  // The sender works in bursts; a fresh burst may open with a gap, during
  // which valid is low. Within a burst valid stays high from one transaction
  // to the next, so it is never lowered and raised in the same time step.
  task automatic send_item(input logic op, input logic go, input logic [3:0] idx,
                           input logic [7:0] val);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: gap = 0;
        6:                gap = $urandom_range(10, 25);
        default:          gap = $urandom_range(1, 4);
      endcase
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 50);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_go         <= go;
    in_char_index <= idx;
    in_char_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Noted here rather than in a monitor, so that the stimulus can read the
    // predicted phase without a race against another process.
    sb.note_item(op, go, idx, val);
    items_sent++;
  endtask

  // Stops offering and waits until every expected result transaction has come.
  // It always waits for a clock edge first, so a following send never meets the
  // lowering of valid in the same time step.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  // The power-up wait register; written only while the block is idle.
  task automatic write_wait_reg(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_wait_ticks(v);
  endtask

  // Result receiver. It switches between stall patterns at random intervals
  // and, once asked, holds out_ready low for a long stretch so that the block
  // fills up and pushes back on its input side.
  initial begin : receiver
    rx_mode_t    rx_mode;
    int          mode_left;
    int          hold_left;
    int unsigned rx_cycle;
    rx_mode   = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    rx_cycle  = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:     out_ready <= 1'b1;
          RX_LIGHT:    out_ready <= ($urandom_range(0, 9) >= 3);
          RX_HEAVY:    out_ready <= ($urandom_range(0, 9) >= 7);
          RX_PERIODIC: out_ready <= (rx_cycle % 4 == 0);
          default:     out_ready <= 1'b1;
        endcase
      end
    end
  end

  // Every accepted result transaction is checked against the oldest
  // prediction. Values read here are those held just before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_bus(out_bus_data, out_lcd_rs, out_lcd_e, out_ready_res);
    end
  end

  initial begin : stimulus
    int          session;
    int          n;
    int          cfg_round;
    logic [7:0]  boot_wait;
    logic [7:0]  wait_val;
    sb        = new();
    session   = 0;
    cfg_round = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The wait register only matters during the power-up wait, so this is the
    // one write whose effect is seen; a zero is meant to behave like one tick.
    case ($urandom_range(0, 3))
      0:       boot_wait = 8'h00;
      1:       boot_wait = 8'h01;
      2:       boot_wait = 8'hFF;
      default: boot_wait = 8'($urandom_range(2, 254));
    endcase
    write_wait_reg(boot_wait);

    // Directed part. Loads before the first tick land in the start state.
    send_item(OP_LOAD, 1'b1, 4'd0, 8'hFF);
    send_item(OP_LOAD, 1'b0, 4'd15, 8'h00);
    // Power-up wait and the four initialisation commands; go has no effect yet.
    while (!sb.ready_q) send_item(OP_TICK, 1'($urandom), 4'($urandom), 8'($urandom));
    // Ready without go stays ready.
    send_item(OP_TICK, 1'b0, 4'h0, 8'h00);
    send_item(OP_LOAD, 1'b0, 4'd7, 8'h5A);
    send_item(OP_LOAD, 1'b1, 4'd8, 8'hA5);
    send_item(OP_LOAD, 1'b0, 4'd15, 8'hFF);
    // Go starts a display run; go held high during the run is ignored, and a
    // load in the middle of the run changes a position not yet written.
    send_item(OP_TICK, 1'b1, 4'hF, 8'hFF);
    n = 0;
    while (sb.phase != PH_HOLD) begin
      if (n == 5) send_item(OP_LOAD, 1'b1, 4'd15, 8'h00);
      else        send_item(OP_TICK, 1'b1, 4'($urandom), 8'($urandom));
      n++;
    end
    // Go still high keeps the block waiting; dropping it makes it ready again.
    send_item(OP_TICK, 1'b1, 4'h0, 8'h00);
    send_item(OP_TICK, 1'b0, 4'hF, 8'hFF);

    // Random part: mostly complete display sessions with random content,
    // the rest bursts of arbitrary transactions.
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        // Fill some of the buffer, then bring the block to ready.
        repeat ($urandom_range(0, 6)) begin
          send_item(OP_LOAD, 1'($urandom), 4'($urandom), 8'($urandom));
        end
        while (sb.phase != PH_READY) send_item(OP_TICK, 1'b0, 4'($urandom), 8'($urandom));
        repeat ($urandom_range(0, 2)) send_item(OP_TICK, 1'b0, 4'($urandom), 8'($urandom));
        send_item(OP_TICK, 1'b1, 4'($urandom), 8'($urandom));
        // The run itself, with go wandering and loads mixed in.
        while (sb.phase != PH_HOLD) begin
          if ($urandom_range(0, 99) < 15) begin
            send_item(OP_LOAD, 1'($urandom), 4'($urandom), 8'($urandom));
          end else begin
            send_item(OP_TICK, 1'($urandom), 4'($urandom), 8'($urandom));
          end
        end
        repeat ($urandom_range(0, 3)) send_item(OP_TICK, 1'b1, 4'($urandom), 8'($urandom));
        send_item(OP_TICK, 1'b0, 4'($urandom), 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 10)) begin
          send_item(1'($urandom), 1'($urandom), 4'($urandom), 8'($urandom));
        end
      end
      session++;

      // One long receiver hold-off while the sender keeps going.
      if (session == 12) hold_request = 1'b1;

      // Now and then let the block empty out and rewrite the wait register.
      if (session % 8 == 7) begin
        drain_results();
        case (cfg_round % 5)
          0:       wait_val = 8'hFF;
          1:       wait_val = 8'h00;
          2:       wait_val = 8'h01;
          3:       wait_val = 8'($urandom_range(2, 254));
          default: wait_val = WAIT_TICKS_RST;
        endcase
        write_wait_reg(wait_val);
        cfg_round++;
      end
    end

    // Let every outstanding result come back, then let the clock run on so that
    // a stray result transaction would still be seen.
    drain_results();
    repeat (8) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d expected result transactions never arrived", sb.pending.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
